### rtl/core/assert_macros.svh
// assertion macros used by free_region_subtractor.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while in reset
`define FRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds in reset
`define FRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/frs_pkg.sv
// package for the free region subtractor: sizes, types and codes
`default_nettype none
package frs_pkg;
  localparam int MaxRegions = 16;
  localparam int CntW = $clog2(MaxRegions + 1);
  localparam int AddrW = 64;

  localparam logic [1:0] FuncAppend   = 2'd0;
  localparam logic [1:0] FuncSubtract = 2'd1;
  localparam logic [1:0] FuncReadout  = 2'd2;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] size;
    logic [AddrW-1:0] last_addr;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic   keep;
    logic   split;
    entry_t piece;
    entry_t upper;
  } cut_res_t;

  typedef enum logic [1:0] {
    StIdle,
    StSub,
    StRead
  } state_e;
endpackage
`default_nettype wire

### rtl/core/frs_cell.sv
// one cell of the region queue: holds one entry, shifts toward the head
`default_nettype none
module frs_cell (
  input  wire logic               clk_i,
  input  wire frs_pkg::cell_ctl_t ctl_i,
  input  wire frs_pkg::entry_t    nbr_i,
  input  wire frs_pkg::entry_t    new_i,
  output frs_pkg::entry_t         entry_o
);
  frs_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load) begin
      entry_d = new_i;
    end else if (ctl_i.shift) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
endmodule
`default_nettype wire

### rtl/core/frs_cut.sv
// cuts a reserved range out of the head region
`default_nettype none
module frs_cut (
  input  wire frs_pkg::entry_t             head_i,
  input  wire logic [frs_pkg::AddrW-1:0]   rsv_base_i,
  input  wire logic [frs_pkg::AddrW-1:0]   rsv_end_i,
  output frs_pkg::cut_res_t                res_o
);
  logic [frs_pkg::AddrW-1:0] gb, ge;
  logic no_ovl, at_front, at_back;

  always_comb begin
    gb = head_i.base;
    ge = head_i.last_addr;
    no_ovl   = (ge <= rsv_base_i) || (rsv_end_i <= gb);
    at_front = rsv_base_i <= gb;
    at_back  = rsv_end_i >= ge;
    res_o.keep  = 1'b1;
    res_o.split = 1'b0;
    res_o.piece = head_i;
    res_o.upper.base      = rsv_end_i;
    res_o.upper.size      = ge - rsv_end_i;
    res_o.upper.last_addr = ge;
    if (no_ovl) begin
      res_o.piece = head_i;
    end else if (at_front && at_back) begin
      res_o.keep = 1'b0;
    end else if (at_front) begin
      res_o.piece = res_o.upper;
    end else begin
      res_o.piece.base      = gb;
      res_o.piece.size      = rsv_base_i - gb;
      res_o.piece.last_addr = rsv_base_i;
      res_o.split           = !at_back;
    end
  end
endmodule
`default_nettype wire

### rtl/core/free_region_subtractor.sv
// append, undefined func and readout of an empty queue register their beat in the accept cycle
// subtract pops one queue cell per cycle, paused while a split piece is inserted
// readout gives one beat per cycle per region while the output is free; a new item is taken once the last beat is out
// the walk over the cell chain plus split inserts must end before a new item is taken
// reset empties the queue and clears output valid; cell contents and output data are not cleared
`default_nettype none
`include "assert_macros.svh"
module free_region_subtractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [63:0] base_addr_i,
  input  wire logic [63:0] length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      region_start_o,
  output logic [63:0]      region_length_o,
  output logic             region_present_o,
  output logic [4:0]       region_total_o,
  output logic             dropped_o,
  output logic             last_of_run_o
);
  localparam int N = frs_pkg::MaxRegions;
  localparam int CW = frs_pkg::CntW;

  frs_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, rem_q, rem_d, wpos;
  logic pend_q, pend_d, lost_q, lost_d;
  frs_pkg::entry_t pend_e_q, pend_e_d;
  logic [63:0] rb_q, rb_d, re_q, re_d;

  frs_pkg::entry_t cells [N];
  frs_pkg::cell_ctl_t ctl [N];
  frs_pkg::entry_t push_e, app_e;
  frs_pkg::cut_res_t cut;
  logic pop, push, accept, out_free, emit;
  logic [64:0] app_sum, rsv_sum;

  logic ov_q;
  logic [63:0] os_q, ol_q;
  logic op_q, od_q, olast_q;
  logic [4:0] ot_q;
  logic [63:0] es, el;
  logic ep, ed, elast;
  logic [4:0] et;

  assign out_free = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == frs_pkg::StIdle) && out_free;
  assign accept = in_valid_i && in_ready_o;

  assign app_sum = {1'b0, base_addr_i} + {1'b0, length_i};
  assign rsv_sum = app_sum;

  always_comb begin
    app_e.base      = base_addr_i;
    app_e.size      = length_i;
    app_e.last_addr = app_sum[64] ? '1 : app_sum[63:0];
  end

  frs_cut u_cut (
    .head_i     (cells[0]),
    .rsv_base_i (rb_q),
    .rsv_end_i  (re_q),
    .res_o      (cut)
  );

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    pend_e_d = pend_e_q;
    lost_d   = lost_q;
    rb_d     = rb_q;
    re_d     = re_q;
    case (state_q)
      frs_pkg::StIdle: begin
        if (accept && func_i == frs_pkg::FuncSubtract) begin
          rb_d    = base_addr_i;
          re_d    = rsv_sum[64] ? '1 : rsv_sum[63:0];
          rem_d   = cnt_q;
          lost_d  = 1'b0;
          pend_d  = 1'b0;
          state_d = frs_pkg::StSub;
        end else if (accept && func_i == frs_pkg::FuncReadout && cnt_q != '0) begin
          rem_d   = cnt_q;
          state_d = frs_pkg::StRead;
        end
      end
      frs_pkg::StSub: begin
        if (pend_q) begin
          pend_d = 1'b0;
        end else if (rem_q != '0) begin
          rem_d = rem_q - 1'b1;
          if (cut.split) begin
            if (cnt_q < CW'(N)) begin
              pend_d   = 1'b1;
              pend_e_d = cut.upper;
            end else begin
              lost_d = 1'b1;
            end
          end
        end else if (out_free) begin
          state_d = frs_pkg::StIdle;
        end
      end
      frs_pkg::StRead: begin
        if (out_free) begin
          rem_d = rem_q - 1'b1;
          if (rem_q == CW'(1)) begin
            state_d = frs_pkg::StIdle;
          end
        end
      end
      default: state_d = frs_pkg::StIdle;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    push   = 1'b0;
    push_e = app_e;
    emit   = 1'b0;
    es     = '0;
    el     = '0;
    ep     = 1'b0;
    ed     = 1'b0;
    elast  = 1'b1;
    et     = 5'(cnt_q);
    case (state_q)
      frs_pkg::StIdle: begin
        if (accept) begin
          if (func_i == frs_pkg::FuncAppend) begin
            emit = 1'b1;
            if (cnt_q < CW'(N)) begin
              push = 1'b1;
              et   = 5'(cnt_q + 1'b1);
            end else begin
              ed = 1'b1;
            end
          end else if (func_i == frs_pkg::FuncReadout) begin
            emit = (cnt_q == '0);
          end else if (func_i != frs_pkg::FuncSubtract) begin
            emit = 1'b1;
          end
        end
      end
      frs_pkg::StSub: begin
        if (pend_q) begin
          push   = 1'b1;
          push_e = pend_e_q;
        end else if (rem_q != '0) begin
          pop    = 1'b1;
          push   = cut.keep;
          push_e = cut.piece;
        end else if (out_free) begin
          emit = 1'b1;
          ed   = lost_q;
        end
      end
      frs_pkg::StRead: begin
        if (out_free) begin
          pop    = 1'b1;
          push   = 1'b1;
          push_e = cells[0];
          emit   = 1'b1;
          es     = cells[0].base;
          el     = cells[0].size;
          ep     = 1'b1;
          elast  = (rem_q == CW'(1));
        end
      end
      default: ;
    endcase
  end

  assign wpos  = pop ? cnt_q - 1'b1 : cnt_q;
  assign cnt_d = cnt_q + CW'(push) - CW'(pop);

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign ctl[i] = '{shift: pop, load: push && (wpos == CW'(i))};
    if (i == N - 1) begin : g_end
      frs_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl[i]),
        .nbr_i   ('0),
        .new_i   (push_e),
        .entry_o (cells[i])
      );
    end else begin : g_mid
      frs_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl[i]),
        .nbr_i   (cells[i+1]),
        .new_i   (push_e),
        .entry_o (cells[i])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frs_pkg::StIdle;
      cnt_q   <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
      lost_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      lost_q  <= lost_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_e_q <= pend_e_d;
    rb_q     <= rb_d;
    re_q     <= re_d;
    if (emit) begin
      os_q    <= es;
      ol_q    <= el;
      op_q    <= ep;
      ot_q    <= et;
      od_q    <= ed;
      olast_q <= elast;
    end
  end

  assign out_valid_o      = ov_q;
  assign region_start_o   = os_q;
  assign region_length_o  = ol_q;
  assign region_present_o = op_q;
  assign region_total_o   = ot_q;
  assign dropped_o        = od_q;
  assign last_of_run_o    = olast_q;

  `FRS_ASSERT(a_cnt_range, cnt_q <= CW'(N), "region count above capacity")
  `FRS_ASSERT(a_pend_in_sub, pend_q |-> state_q == frs_pkg::StSub, "split piece held outside subtract")
  `FRS_ASSERT(a_pend_room, pend_q |-> cnt_q < CW'(N), "split piece held with no room")
  `FRS_ASSERT_ALWAYS(a_ready_idle, in_ready_o |-> state_q == frs_pkg::StIdle, "ready while busy")
endmodule
`default_nettype wire
